// ===== hdl/rtbm_pkg.sv =====
// ----------------------------------------------------------------------------
// rtbm_pkg
// shared constants, types and the cordic arctangent table for the
// radial table boundary mask
// ----------------------------------------------------------------------------
package rtbm_pkg;

  localparam int DEF_TABLE_DEPTH = 256;
  localparam int DEF_COUNT_WIDTH = 24;
  localparam int CORDIC_STEPS    = 30;

  localparam logic [2:0] REG_INNER_BOUND    = 3'd0;
  localparam logic [2:0] REG_OUTER_BOUND    = 3'd1;
  localparam logic [2:0] REG_ANGLE_STEP     = 3'd2;
  localparam logic [2:0] REG_INV_ANGLE_STEP = 3'd3;
  localparam logic [2:0] REG_INTERP_MODE    = 3'd4;

  localparam logic CMD_LOAD     = 1'b0;
  localparam logic CMD_CLASSIFY = 1'b1;

  localparam logic [1:0] ADD_B  = 2'd0;
  localparam logic [1:0] ADD_D0 = 2'd1;
  localparam logic [1:0] ADD_F0 = 2'd2;

  typedef struct packed {
    logic       latch;
    logic       load_wr;
    logic       check;
    logic       cordic_step;
    logic [4:0] cordic_idx;
    logic       pos_mul;
    logic       pos_cap;
    logic       rd;
    logic       rd_sel;
    logic       cap_f0;
    logic       cap_f1;
    logic       dmul0;
    logic       dmul1;
    logic       dcap;
    logic       lin_init;
    logic       coef;
    logic       hmul;
    logic       hadd;
    logic [1:0] hsel;
    logic       cmp;
    logic       finish;
  } rtbm_cmd_t;

  typedef struct packed {
    logic above_outer;
    logic below_inner;
    logic out_busy;
    logic cubic;
  } rtbm_status_t;

  function automatic logic signed [32:0] atan_entry(input logic [4:0] i);
    logic signed [32:0] v;
    unique case (i)
      5'd0:  v = 33'sh03243F6A8;
      5'd1:  v = 33'sh01DAC6705;
      5'd2:  v = 33'sh00FADBAFC;
      5'd3:  v = 33'sh007F56EA6;
      5'd4:  v = 33'sh003FEAB76;
      5'd5:  v = 33'sh001FFD55B;
      5'd6:  v = 33'sh000FFFAAA;
      5'd7:  v = 33'sh0007FFF55;
      5'd8:  v = 33'sh0003FFFEA;
      5'd9:  v = 33'sh0001FFFFD;
      5'd10: v = 33'sh0000FFFFF;
      5'd11: v = 33'sh00007FFFF;
      5'd12: v = 33'sh00003FFFF;
      5'd13: v = 33'sh00001FFFF;
      5'd14: v = 33'sh00000FFFF;
      5'd15: v = 33'sh000007FFF;
      5'd16: v = 33'sh000003FFF;
      5'd17: v = 33'sh000001FFF;
      5'd18: v = 33'sh000000FFF;
      5'd19: v = 33'sh0000007FF;
      5'd20: v = 33'sh0000003FF;
      5'd21: v = 33'sh0000001FF;
      5'd22: v = 33'sh0000000FF;
      5'd23: v = 33'sh00000007F;
      5'd24: v = 33'sh00000003F;
      5'd25: v = 33'sh00000001F;
      5'd26: v = 33'sh00000000F;
      5'd27: v = 33'sh000000008;
      5'd28: v = 33'sh000000004;
      5'd29: v = 33'sh000000002;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/rtbm_ctrl.sv =====
// ----------------------------------------------------------------------------
// rtbm_ctrl
// sequencer: table loads, bounds check, cordic iterations, table reads, horner steps
// ----------------------------------------------------------------------------
module rtbm_ctrl
  import rtbm_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic         in_cmd,
  output logic         in_ready,
  input  rtbm_status_t status,
  output rtbm_cmd_t    cmd
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_LOAD  = 5'd1;
  localparam logic [4:0] S_CHECK = 5'd2;
  localparam logic [4:0] S_CORD  = 5'd3;
  localparam logic [4:0] S_PMUL  = 5'd4;
  localparam logic [4:0] S_PCAP  = 5'd5;
  localparam logic [4:0] S_RD0   = 5'd6;
  localparam logic [4:0] S_RD1   = 5'd7;
  localparam logic [4:0] S_RD2   = 5'd8;
  localparam logic [4:0] S_LIN   = 5'd9;
  localparam logic [4:0] S_DMUL0 = 5'd10;
  localparam logic [4:0] S_DMUL1 = 5'd11;
  localparam logic [4:0] S_DCAP  = 5'd12;
  localparam logic [4:0] S_COEF  = 5'd13;
  localparam logic [4:0] S_HMUL  = 5'd14;
  localparam logic [4:0] S_HADD  = 5'd15;
  localparam logic [4:0] S_CMP   = 5'd16;
  localparam logic [4:0] S_FIN   = 5'd17;

  localparam logic [4:0] LAST_STEP = 5'(CORDIC_STEPS - 1);

  logic [4:0] state, state_next;
  logic [4:0] step, step_next;
  logic [1:0] hstep, hstep_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    step_next  = step;
    hstep_next = hstep;
    cmd        = '0;
    cmd.cordic_idx = step;
    cmd.hsel       = hstep;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = (in_cmd == CMD_LOAD) ? S_LOAD : S_CHECK;
        end
      end
      S_LOAD: begin
        cmd.load_wr = 1'b1;
        state_next  = S_IDLE;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        step_next = '0;
        if (status.above_outer || status.below_inner) begin
          state_next = S_FIN;
        end else begin
          state_next = S_CORD;
        end
      end
      S_CORD: begin
        cmd.cordic_step = 1'b1;
        step_next       = step + 5'd1;
        if (step == LAST_STEP) begin
          state_next = S_PMUL;
        end
      end
      S_PMUL: begin
        cmd.pos_mul = 1'b1;
        state_next  = S_PCAP;
      end
      S_PCAP: begin
        cmd.pos_cap = 1'b1;
        state_next  = S_RD0;
      end
      S_RD0: begin
        cmd.rd     = 1'b1;
        state_next = S_RD1;
      end
      S_RD1: begin
        cmd.rd     = 1'b1;
        cmd.rd_sel = 1'b1;
        cmd.cap_f0 = 1'b1;
        state_next = S_RD2;
      end
      S_RD2: begin
        cmd.cap_f1 = 1'b1;
        state_next = status.cubic ? S_DMUL0 : S_LIN;
      end
      S_LIN: begin
        cmd.lin_init = 1'b1;
        hstep_next   = ADD_F0;
        state_next   = S_HMUL;
      end
      S_DMUL0: begin
        cmd.dmul0  = 1'b1;
        state_next = S_DMUL1;
      end
      S_DMUL1: begin
        cmd.dmul1  = 1'b1;
        state_next = S_DCAP;
      end
      S_DCAP: begin
        cmd.dcap   = 1'b1;
        state_next = S_COEF;
      end
      S_COEF: begin
        cmd.coef   = 1'b1;
        hstep_next = ADD_B;
        state_next = S_HMUL;
      end
      S_HMUL: begin
        cmd.hmul   = 1'b1;
        state_next = S_HADD;
      end
      S_HADD: begin
        cmd.hadd = 1'b1;
        if (hstep == ADD_F0) begin
          state_next = S_CMP;
        end else begin
          hstep_next = hstep + 2'd1;
          state_next = S_HMUL;
        end
      end
      S_CMP: begin
        cmd.cmp    = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!status.out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
      hstep <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
      hstep <= hstep_next;
    end
  end

endmodule

// ===== hdl/rtbm_dp.sv =====
// ----------------------------------------------------------------------------
// rtbm_dp
// datapath: config registers, boundary tables, cordic, multipliers,
// inside counter and output register
// ----------------------------------------------------------------------------
module rtbm_dp
  import rtbm_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic [1:0]   in_user,
  input  logic [167:0] in_data,
  input  rtbm_cmd_t    cmd,
  output rtbm_status_t status,
  input  logic         out_ready,
  output logic         out_valid,
  output logic [31:0]  out_data
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic [16:0] K_LAST = 17'(TABLE_DEPTH - 1);
  localparam logic [AW-1:0] K_CLAMP = AW'(TABLE_DEPTH - 2);

  logic [31:0] inner_bound, outer_bound, inv_angle_step;
  logic [30:0] angle_step;
  logic        interp_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      inner_bound    <= 32'd0;
      outer_bound    <= 32'hFFFF_FFFF;
      angle_step     <= 31'd6588397;
      inv_angle_step <= 32'd10680707;
      interp_mode    <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INNER_BOUND:    inner_bound    <= cfg_data;
        REG_OUTER_BOUND:    outer_bound    <= cfg_data;
        REG_ANGLE_STEP:     angle_step     <= cfg_data[30:0];
        REG_INV_ANGLE_STEP: inv_angle_step <= cfg_data;
        REG_INTERP_MODE:    interp_mode    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // latched item
  logic        start_r;
  logic [7:0]  idx_r;
  logic [31:0] val_r, slope_r, rad_r, ax_r, pr_r;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      start_r <= in_user[1];
      idx_r   <= in_data[7:0];
      val_r   <= in_data[39:8];
      slope_r <= in_data[71:40];
      rad_r   <= in_data[103:72];
      ax_r    <= in_data[135:104];
      pr_r    <= in_data[167:136];
    end
  end

  assign status.above_outer = pr_r > outer_bound;
  assign status.below_inner = pr_r < inner_bound;
  assign status.cubic       = interp_mode;

  // tables
  logic [31:0]     mem_rad   [TABLE_DEPTH];
  logic [31:0]     mem_slope [TABLE_DEPTH];
  logic [AW+7:0]   idx_wide;
  logic [AW-1:0]   wr_addr, rd_addr, k_r;
  logic            idx_ok;
  logic [31:0]     rd_rad, rd_slope;

  assign idx_wide = {AW'(0), idx_r};
  assign wr_addr  = idx_wide[AW-1:0];
  assign idx_ok   = 32'(idx_r) < 32'(TABLE_DEPTH);
  assign rd_addr  = cmd.rd_sel ? k_r + AW'(1) : k_r;

  always_ff @(posedge clk) begin
    if (cmd.load_wr && idx_ok) begin
      mem_rad[wr_addr] <= val_r;
    end
    if (cmd.rd) begin
      rd_rad <= mem_rad[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_wr && idx_ok && interp_mode) begin
      mem_slope[wr_addr] <= slope_r;
    end
    if (cmd.rd) begin
      rd_slope <= mem_slope[rd_addr];
    end
  end

  // cordic vectoring
  logic signed [34:0] cx, cy, xs, ys;
  logic signed [32:0] th, atan_v, thc;

  assign xs     = cx >>> cmd.cordic_idx;
  assign ys     = cy >>> cmd.cordic_idx;
  assign atan_v = atan_entry(cmd.cordic_idx);
  assign thc    = (rad_r == 32'd0 || th[32]) ? 33'sd0 : th;

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      cx <= $signed({3'b0, ax_r});
      cy <= $signed({3'b0, rad_r});
      th <= '0;
    end else if (cmd.cordic_step) begin
      if (!cy[34]) begin
        cx <= cx + ys;
        cy <= cy - xs;
        th <= th + atan_v;
      end else begin
        cx <= cx - ys;
        cy <= cy + xs;
        th <= th - atan_v;
      end
    end
  end

  // position and derivative multiplier
  logic signed [32:0] m1a, m1b;
  logic signed [65:0] p1;
  logic [16:0]        t_r;
  logic [31:0]        f0, f1, s0, s1;
  logic signed [32:0] d0, d1;

  always_comb begin
    if (cmd.pos_mul) begin
      m1a = thc;
      m1b = $signed({1'b0, inv_angle_step});
    end else begin
      m1a = $signed({2'b0, angle_step});
      m1b = cmd.dmul1 ? $signed({s1[31], s1}) : $signed({s0[31], s0});
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pos_mul || cmd.dmul0 || cmd.dmul1) begin
      p1 <= m1a * m1b;
    end
    if (cmd.pos_cap) begin
      if (p1[62:46] >= K_LAST) begin
        k_r <= K_CLAMP;
        t_r <= 17'h10000;
      end else begin
        k_r <= p1[AW+45:46];
        t_r <= {1'b0, p1[45:30]};
      end
    end
    if (cmd.cap_f0) begin
      f0 <= rd_rad;
      s0 <= rd_slope;
    end
    if (cmd.cap_f1) begin
      f1 <= rd_rad;
      s1 <= rd_slope;
    end
    if (cmd.dmul1) begin
      d0 <= p1[62:30];
    end
    if (cmd.dcap) begin
      d1 <= p1[62:30];
    end
  end

  // horner evaluation
  logic signed [47:0] f0e, f1e, d0e, d1e, acc, b_r, addend;
  logic signed [65:0] p2;

  assign f0e = $signed({16'b0, f0});
  assign f1e = $signed({16'b0, f1});
  assign d0e = {{15{d0[32]}}, d0};
  assign d1e = {{15{d1[32]}}, d1};

  always_comb begin
    case (cmd.hsel)
      ADD_B:   addend = b_r;
      ADD_D0:  addend = d0e;
      default: addend = f0e;
    endcase
  end

  logic mask_r;

  always_ff @(posedge clk) begin
    if (cmd.lin_init) begin
      acc <= f1e - f0e;
    end else if (cmd.coef) begin
      acc <= 48'sd2 * f0e - 48'sd2 * f1e + d0e + d1e;
      b_r <= 48'sd3 * f1e - 48'sd3 * f0e - 48'sd2 * d0e - d1e;
    end else if (cmd.hadd) begin
      acc <= addend + $signed(p2[63:16]);
    end
    if (cmd.hmul) begin
      p2 <= acc * $signed({1'b0, t_r});
    end
    if (cmd.check) begin
      mask_r <= status.above_outer;
    end else if (cmd.cmp) begin
      mask_r <= $signed({16'b0, pr_r}) > acc;
    end
  end

  // inside counter and output register
  logic [COUNT_WIDTH-1:0]    count, cnt_base;
  logic [COUNT_WIDTH+23:0]   cnt_ext;
  logic                      out_mask;

  assign cnt_base        = start_r ? '0 : count;
  assign cnt_ext         = {24'(0), count};
  assign status.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
        if (!mask_r && cnt_base != '1) begin
          count <= cnt_base + COUNT_WIDTH'(1);
        end else begin
          count <= cnt_base;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_mask <= mask_r;
    end
  end

  assign out_data = {7'b0, cnt_ext[23:0], out_mask};

endmodule

// ===== hdl/radial_table_boundary_mask.sv =====
// ----------------------------------------------------------------------------
// radial_table_boundary_mask
// classifies grid points against an angular table of boundary radii
// ----------------------------------------------------------------------------
// load item: no result
// classify item: ends after the check when a bound decides, else runs the
//   30 cordic iterations, the table reads and the serial horner multiplier
// one item in flight; result held in an output register
// synchronous reset: config registers to reset values, count cleared, tables kept
module radial_table_boundary_mask
  import rtbm_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  // entry_index, boundary_value, boundary_slope, radial_coord, axial_coord,
  // point_radius
  input  logic [167:0] s_tdata,
  // cmd, start_of_grid
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // mask_bit, inside_count, zero fill
  output logic [31:0]  m_tdata
);

  rtbm_cmd_t    cmd;
  rtbm_status_t status;

  assign cfg_ready = 1'b1;

  rtbm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_cmd   (s_tuser[0]),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  rtbm_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_user   (s_tuser),
    .in_data   (s_tdata),
    .cmd       (cmd),
    .status    (status),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_data  (m_tdata)
  );

endmodule
